FILE: rtl/ohq_pkg.sv
// Shared types and codes for the ordered handle queue.
package ohq_pkg;

    localparam int HANDLE_W     = 4;
    localparam int KEY_W        = 32;
    localparam int COUNT_W      = 5;
    localparam int STATUS_W     = 2;
    localparam int CMD_W        = 3;
    localparam int HANDLE_SPACE = 16;
    localparam int IDX_W        = 9;

    localparam logic [CMD_W-1:0] CMD_ADD_TAIL    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ADD_HEAD    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_ADD_ORDERED = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SERVE       = 3'd3;
    localparam logic [CMD_W-1:0] CMD_REMOVE      = 3'd4;
    localparam logic [CMD_W-1:0] CMD_MOVE_TAIL   = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD   = 2'd2;

    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_HOLD     = 3'd0;
    localparam logic [OP_W-1:0] OP_INS_HEAD = 3'd1;
    localparam logic [OP_W-1:0] OP_INS_TAIL = 3'd2;
    localparam logic [OP_W-1:0] OP_INS_ORD  = 3'd3;
    localparam logic [OP_W-1:0] OP_REM_HEAD = 3'd4;
    localparam logic [OP_W-1:0] OP_REM_HIT  = 3'd5;
    localparam logic [OP_W-1:0] OP_MOVE     = 3'd6;

    typedef logic [HANDLE_W-1:0] handle_t;
    typedef logic signed [KEY_W-1:0] key_t;
    typedef logic [COUNT_W-1:0] count_t;

    typedef struct packed {
        logic            cmp_en;
        logic [OP_W-1:0] op;
        handle_t         handle;
        key_t            key;
        count_t          count;
    } cell_ctrl_t;

endpackage

FILE: rtl/ordered_handle_queue_top.sv
// Top level of the ordered handle queue: command sequencer and chain of list cells.
//
// Ordered list of up to ENTRIES handles (at most 16 distinct) with signed keys, position 0 at
// the head. Each command word passes through two phases: a compare phase in which every cell
// compares its key and handle against the command in parallel, and an update phase in which
// the cells from the chosen position on shift by one place toward the head or the tail. A new
// word is taken in the cycle the previous one finishes its update, so none is taken while the
// last one is still in progress; the single result register holds the update back only when
// an earlier result is still stalled. No clearing pass after reset.
module ordered_handle_queue_top #(
    parameter int ENTRIES = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [ohq_pkg::CMD_W-1:0]      cmd,
    input  logic [ohq_pkg::HANDLE_W-1:0]   handle,
    input  logic signed [ohq_pkg::KEY_W-1:0] key,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [ohq_pkg::HANDLE_W-1:0]   served_handle,
    output logic [ohq_pkg::STATUS_W-1:0]   status,
    output logic [ohq_pkg::COUNT_W-1:0]    count
);
    import ohq_pkg::*;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_CMP  = 2'd1;
    localparam logic [1:0] PH_UPD  = 2'd2;

    logic [1:0]              phase_reg, phase_next;
    logic [CMD_W-1:0]        cmd_reg;
    handle_t                 handle_reg;
    key_t                    key_reg;
    count_t                  count_reg, count_next;
    logic [HANDLE_SPACE-1:0] member_reg, member_next;
    logic                    out_valid_reg;
    handle_t                 served_reg, served_next;
    logic [STATUS_W-1:0]     status_reg, status_next;
    logic [OP_W-1:0]         op;
    logic                    in_acc;
    logic                    upd_fire;
    logic                    present;
    logic                    full;
    cell_ctrl_t              ctrl;

    handle_t cell_handle [ENTRIES];
    key_t    cell_key    [ENTRIES];
    logic    ahead       [ENTRIES+1];

    assign upd_fire = (phase_reg == PH_UPD) && !(out_valid_reg && out_stall);
    assign in_stall = !((phase_reg == PH_IDLE) || upd_fire);
    assign in_acc   = in_valid && !in_stall;
    assign present  = member_reg[handle_reg];
    assign full     = int'(count_reg) >= ENTRIES;

    always_comb
    begin
        phase_next = phase_reg;
        if (in_acc)
            phase_next = PH_CMP;
        else if (phase_reg == PH_CMP)
            phase_next = PH_UPD;
        else if (upd_fire)
            phase_next = PH_IDLE;
    end

    always_comb
    begin
        op          = OP_HOLD;
        count_next  = count_reg;
        member_next = member_reg;
        served_next = '0;
        status_next = ST_OK;
        case (cmd_reg) inside
            CMD_ADD_TAIL, CMD_ADD_HEAD, CMD_ADD_ORDERED:
            begin
                if (present || full)
                    status_next = ST_BAD;
                else
                begin
                    op = (cmd_reg == CMD_ADD_TAIL) ? OP_INS_TAIL :
                         (cmd_reg == CMD_ADD_HEAD) ? OP_INS_HEAD : OP_INS_ORD;
                    count_next              = count_reg + COUNT_W'(1);
                    member_next[handle_reg] = 1'b1;
                end
            end
            CMD_SERVE:
            begin
                if (count_reg == '0)
                    status_next = ST_EMPTY;
                else
                begin
                    op                        = OP_REM_HEAD;
                    served_next               = cell_handle[0];
                    count_next                = count_reg - COUNT_W'(1);
                    member_next[cell_handle[0]] = 1'b0;
                end
            end
            CMD_REMOVE, CMD_MOVE_TAIL:
            begin
                if (!present)
                    status_next = ST_BAD;
                else if (cmd_reg == CMD_REMOVE)
                begin
                    op                      = OP_REM_HIT;
                    count_next              = count_reg - COUNT_W'(1);
                    member_next[handle_reg] = 1'b0;
                end
                else
                    op = OP_MOVE;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            count_reg     <= '0;
            member_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            if (upd_fire)
            begin
                count_reg     <= count_next;
                member_reg    <= member_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            cmd_reg    <= cmd;
            handle_reg <= handle;
            key_reg    <= key;
        end
        if (upd_fire)
        begin
            served_reg <= served_next;
            status_reg <= status_next;
        end
    end

    assign ctrl.cmp_en = phase_reg == PH_CMP;
    assign ctrl.op     = upd_fire ? op : OP_HOLD;
    assign ctrl.handle = handle_reg;
    assign ctrl.key    = key_reg;
    assign ctrl.count  = count_reg;

    assign ahead[0] = 1'b0;

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        handle_t lh, rh;
        key_t    lk, rk;

        if (i == 0)
        begin : g_first
            assign lh = handle_reg;
            assign lk = key_reg;
        end
        else
        begin : g_mid
            assign lh = cell_handle[i-1];
            assign lk = cell_key[i-1];
        end

        // beyond the last cell nothing valid comes in
        if (i == ENTRIES - 1)
        begin : g_last
            assign rh = handle_reg;
            assign rk = key_reg;
        end
        else
        begin : g_inner
            assign rh = cell_handle[i+1];
            assign rk = cell_key[i+1];
        end

        ohq_cell #(
            .IDX(i)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctrl         (ctrl),
            .left_handle  (lh),
            .left_key     (lk),
            .right_handle (rh),
            .right_key    (rk),
            .before_in    (ahead[i]),
            .before_out   (ahead[i+1]),
            .handle_q     (cell_handle[i]),
            .key_q        (cell_key[i])
        );
    end

    assign out_valid     = out_valid_reg;
    assign served_handle = served_reg;
    assign status        = status_reg;
    assign count         = count_reg;

endmodule

FILE: rtl/ohq_cell.sv
// One list position: holds a handle and key, shifts left or right on update.
module ohq_cell #(
    parameter int IDX = 0
) (
    input  logic               clk,
    input  logic               rst_n,
    input  ohq_pkg::cell_ctrl_t ctrl,
    input  ohq_pkg::handle_t   left_handle,
    input  ohq_pkg::key_t      left_key,
    input  ohq_pkg::handle_t   right_handle,
    input  ohq_pkg::key_t      right_key,
    input  logic               before_in,
    output logic               before_out,
    output ohq_pkg::handle_t   handle_q,
    output ohq_pkg::key_t      key_q
);
    import ohq_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    handle_t          handle_reg;
    key_t             key_reg;
    logic             gt_reg;
    logic             hit_reg;
    logic [IDX_W-1:0] cnt_ext;
    logic             valid;
    logic             at_count;
    logic             at_last;
    logic             flag;
    logic             sel;
    logic             do_rem;

    assign cnt_ext  = {{(IDX_W-COUNT_W){1'b0}}, ctrl.count};
    assign valid    = MY_IDX < cnt_ext;
    assign at_count = MY_IDX == cnt_ext;
    assign at_last  = (MY_IDX + IDX_W'(1)) == cnt_ext;

    // compare flags are registered in the compare phase and used by the later update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gt_reg  <= 1'b0;
            hit_reg <= 1'b0;
        end
        else if (ctrl.cmp_en)
        begin
            gt_reg  <= valid && (ctrl.key < key_reg);
            hit_reg <= valid && (ctrl.handle == handle_reg);
        end
    end

    always_comb
    begin
        unique case (ctrl.op)
            OP_INS_HEAD: flag = MY_IDX == '0;
            OP_INS_TAIL: flag = at_count;
            OP_INS_ORD:  flag = gt_reg || at_count;
            OP_REM_HEAD: flag = MY_IDX == '0;
            OP_REM_HIT:  flag = hit_reg;
            OP_MOVE:     flag = hit_reg;
            default:     flag = 1'b0;
        endcase
    end

    assign sel        = flag && !before_in;
    assign before_out = before_in || sel;
    assign do_rem     = (ctrl.op == OP_REM_HEAD) || (ctrl.op == OP_REM_HIT)
                        || (ctrl.op == OP_MOVE);

    always_ff @(posedge clk)
    begin
        if (ctrl.op == OP_MOVE && at_last)
        begin
            handle_reg <= ctrl.handle;
            key_reg    <= ctrl.key;
        end
        else if (do_rem)
        begin
            if (sel || before_in)
            begin
                handle_reg <= right_handle;
                key_reg    <= right_key;
            end
        end
        else if (ctrl.op != OP_HOLD)
        begin
            if (sel)
            begin
                handle_reg <= ctrl.handle;
                key_reg    <= ctrl.key;
            end
            else if (before_in)
            begin
                handle_reg <= left_handle;
                key_reg    <= left_key;
            end
        end
    end

    assign handle_q = handle_reg;
    assign key_q    = key_reg;

endmodule
